>>> design/prle_pkg.sv
// Shared types, constants and the colour packing function for the
// palette run-length sprite line decoder. No dependencies.
package prle_pkg;

	localparam int MAX_LINE_WIDTH  = 4096;
	localparam int PALETTE_ENTRIES = 256;
	localparam int COL_W = $clog2(MAX_LINE_WIDTH + 1);
	localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
	localparam int RUN_W = 6;
	localparam int ALPHA_W = 5;

	// command field, top two bits of a flag byte
	localparam logic [1:0] CMD_ALPHA   = 2'b00;
	localparam logic [1:0] CMD_LITERAL = 2'b01;
	localparam logic [1:0] CMD_REPEAT  = 2'b10;
	localparam logic [1:0] CMD_SKIP    = 2'b11;

	localparam logic REQ_PALETTE = 1'b0;
	localparam logic REQ_STREAM  = 1'b1;

	localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 5'h1F;

	typedef enum logic [2:0] {
		PH_FLAG,
		PH_APIX_INDEX,
		PH_ARUN_ALPHA,
		PH_ARUN_INDEX,
		PH_LITERAL,
		PH_REPEAT_INDEX,
		PH_DONE
	} phase_t;

	// RGB565 plus alpha to the packed output word
	function automatic logic [31:0] expand(input logic [15:0] c, input logic [4:0] a);
		expand = {a, 3'b000, c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
	endfunction

endpackage

>>> design/prle_ifs.sv
// Handshake channels of the decoder: requests in, pixels out, width register.
// Depends on prle_pkg for field widths.
interface prle_req_if import prle_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [PAL_AW-1:0]   palette_index;
	logic [15:0]         color565;
	logic [7:0]          stream_byte;
	logic                line_start;
	modport source (output valid, req_type, palette_index, color565, stream_byte, line_start,
		input ready);
	modport sink (input valid, req_type, palette_index, color565, stream_byte, line_start,
		output ready);
endinterface

interface prle_pix_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_x;
	logic [31:0] pixel_value;
	logic        last_pixel;
	modport source (output valid, pixel_x, pixel_value, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_value, last_pixel, output ready);
endinterface

interface prle_cfg_if;
	logic        valid;
	logic        ready;
	logic [11:0] line_width;
	modport source (output valid, line_width, input ready);
	modport sink (input valid, line_width, output ready);
endinterface

>>> design/palette_rle_sprite_line_decoder.sv
// A byte that gives pixels is registered at acceptance in the emit counter and palette
// read register. Palette writes and bytes that give no pixel leave the request channel
// ready; a byte that gives n pixels holds it until all n reach the output register, one
// per cycle unless the output stalls, fed by a single palette read taken at acceptance.
// Reset: parser expects a flag, column and width are zero; palette contents are
// undefined until written and get no clearing pass.
module palette_rle_sprite_line_decoder import prle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	prle_req_if.sink   req,
	prle_pix_if.source pix,
	prle_cfg_if.sink   cfg
);

	logic [15:0]        pal_mem [PALETTE_ENTRIES];
	logic [15:0]        pal_rdata_q;

	logic [11:0]        lw_q;
	phase_t             phase_q, phase_d;
	logic [RUN_W-1:0]   run_q, run_d;
	logic [ALPHA_W-1:0] alpha_q, alpha_d;
	logic [COL_W-1:0]   col_q, col_d;

	logic [RUN_W-1:0]   emit_cnt_q;
	logic [11:0]        emit_x_q;
	logic [ALPHA_W-1:0] emit_alpha_q;

	logic               out_valid_q;
	logic [11:0]        out_x_q;
	logic [31:0]        out_val_q;
	logic               out_last_q;

	// effective parser state after an optional line restart
	phase_t             ph_eff;
	logic [RUN_W-1:0]   run_eff;
	logic [ALPHA_W-1:0] alpha_eff;
	logic [COL_W-1:0]   col_eff;

	logic               do_emit;
	logic [RUN_W-1:0]   adv_k;
	logic [ALPHA_W-1:0] pix_alpha;
	logic [COL_W:0]     col_sum;
	logic [COL_W-1:0]   end_col;
	logic [RUN_W-1:0]   emit_n;
	logic               acc, acc_stream, acc_pal, load;
	logic [7:0]         b;

	assign acc        = req.valid && req.ready;
	assign acc_stream = acc && (req.req_type == REQ_STREAM);
	assign acc_pal    = acc && (req.req_type == REQ_PALETTE);
	assign b          = req.stream_byte;

	assign ph_eff    = req.line_start ? PH_FLAG : phase_q;
	assign run_eff   = req.line_start ? '0 : run_q;
	assign alpha_eff = req.line_start ? '0 : alpha_q;
	assign col_eff   = req.line_start ? '0 : col_q;

	// parser next state
	always_comb begin
		phase_d   = ph_eff;
		run_d     = run_eff;
		alpha_d   = alpha_eff;
		do_emit   = 1'b0;
		adv_k     = '0;
		pix_alpha = ALPHA_OPAQUE;
		case (ph_eff)
			PH_FLAG: begin
				if (col_eff >= COL_W'(lw_q) || b == 8'h00) begin
					phase_d = PH_DONE;
				end else begin
					case (b[7:6])
						CMD_ALPHA: begin
							if (b[5]) begin
								alpha_d = b[4:0];
								phase_d = PH_APIX_INDEX;
							end else begin
								run_d   = {1'b0, b[4:0]};
								phase_d = PH_ARUN_ALPHA;
							end
						end
						CMD_LITERAL: begin
							run_d = b[5:0];
							if (b[5:0] != '0)
								phase_d = PH_LITERAL;
						end
						CMD_REPEAT: begin
							run_d   = b[5:0];
							phase_d = PH_REPEAT_INDEX;
						end
						CMD_SKIP: adv_k = b[5:0];
						default: ;
					endcase
				end
			end
			PH_APIX_INDEX: begin
				do_emit   = 1'b1;
				adv_k     = RUN_W'(1);
				pix_alpha = alpha_eff;
				phase_d   = PH_FLAG;
			end
			PH_ARUN_ALPHA: begin
				alpha_d = b[4:0];
				phase_d = PH_ARUN_INDEX;
			end
			PH_ARUN_INDEX: begin
				do_emit   = 1'b1;
				adv_k     = run_eff;
				pix_alpha = alpha_eff;
				run_d     = '0;
				phase_d   = PH_FLAG;
			end
			PH_LITERAL: begin
				do_emit = 1'b1;
				adv_k   = RUN_W'(1);
				run_d   = run_eff - RUN_W'(1);
				if (run_d == '0)
					phase_d = PH_FLAG;
			end
			PH_REPEAT_INDEX: begin
				do_emit = 1'b1;
				adv_k   = run_eff;
				run_d   = '0;
				phase_d = PH_FLAG;
			end
			default: ;
		endcase
	end

	// column advance and count of visible pixels
	always_comb begin
		col_sum = {1'b0, col_eff} + (COL_W + 1)'(adv_k);
		col_d   = (col_sum > (COL_W + 1)'(MAX_LINE_WIDTH)) ? COL_W'(MAX_LINE_WIDTH)
			: col_sum[COL_W-1:0];
		end_col = (col_sum < (COL_W + 1)'(lw_q)) ? col_sum[COL_W-1:0] : COL_W'(lw_q);
		emit_n  = (do_emit && col_eff < COL_W'(lw_q)) ? RUN_W'(end_col - col_eff) : '0;
	end

	assign req.ready = (emit_cnt_q == '0);
	assign cfg.ready = 1'b1;
	assign load      = (emit_cnt_q != '0) && (!out_valid_q || pix.ready);

	always_ff @(posedge clk) begin
		if (acc_pal)
			pal_mem[req.palette_index] <= req.color565;
		if (acc_stream)
			pal_rdata_q <= pal_mem[b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q    <= '0;
			phase_q <= PH_FLAG;
			run_q   <= '0;
			alpha_q <= '0;
			col_q   <= '0;
		end else begin
			if (cfg.valid)
				lw_q <= cfg.line_width;
			if (acc_stream) begin
				phase_q <= phase_d;
				run_q   <= run_d;
				alpha_q <= alpha_d;
				col_q   <= col_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_stream)
				emit_cnt_q <= emit_n;
			else if (load)
				emit_cnt_q <= emit_cnt_q - RUN_W'(1);
			if (load)
				out_valid_q <= 1'b1;
			else if (pix.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_stream) begin
			emit_x_q     <= col_eff[11:0];
			emit_alpha_q <= pix_alpha;
		end else if (load) begin
			emit_x_q <= emit_x_q + 12'd1;
		end
		if (load) begin
			out_x_q    <= emit_x_q;
			out_val_q  <= expand(pal_rdata_q, emit_alpha_q);
			out_last_q <= (emit_cnt_q == RUN_W'(1));
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.pixel_x     = out_x_q;
	assign pix.pixel_value = out_val_q;
	assign pix.last_pixel  = out_last_q;

	a_col_sat: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(MAX_LINE_WIDTH))
		else $error("column beyond saturation limit");

	a_x_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid |-> pix.pixel_x < lw_q)
		else $error("pixel emitted beyond line width");

	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready && !pix.last_pixel |=> pix.valid)
		else $error("gap inside a pixel run");

	a_run_step: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready && !pix.last_pixel |=>
		pix.pixel_x == 12'($past(pix.pixel_x) + 12'd1))
		else $error("run columns not consecutive");

endmodule
